@@ src/cau_pkg.sv @@
// shared types for the complex arithmetic unit
// no dependencies; imported by every cau module
package cau_pkg;

  // operation codes carried in the input tuser field
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  // per-item control flags, lane 0 is the real part, lane 1 the imaginary part
  typedef struct packed {
    logic       is_div;
    logic       dz;
    logic [1:0] neg;
    logic [1:0] big;
  } cau_flags_t;

endpackage

@@ src/cau_front.sv @@
// front end: products, sums, magnitudes and divider setup in four stages
// depends on cau_pkg
module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cau_op_t                        in_action,
  input  logic signed [DATA_WIDTH-1:0]   a_re,
  input  logic signed [DATA_WIDTH-1:0]   a_im,
  input  logic signed [DATA_WIDTH-1:0]   b_re,
  input  logic signed [DATA_WIDTH-1:0]   b_im,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cau_flags_t                     out_flags,
  output logic [2*DATA_WIDTH-1:0]        out_den,
  output logic [2*DATA_WIDTH-1:0]        out_r   [2],
  output logic [DATA_WIDTH:0]            out_q   [2],
  output logic [DATA_WIDTH:0]            out_lo  [2]
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int RW = 2 * W;
  localparam int QW = W + 1;
  localparam int DW = 2 * W + FRAC_BITS;

  // stage 1: products and add/subtract
  logic                 v1;
  cau_op_t              op1;
  logic signed [PW-1:0] prr1, pii1, pri1, pir1, srr1, sii1;
  logic        [W:0]    add_re1, add_im1;
  // stage 2: signed numerators and divisor
  logic                 v2;
  cau_op_t              op2;
  logic        [SW-1:0] num2 [2];
  logic        [RW-1:0] den2;
  // stage 3: sign and magnitude
  logic                 v3;
  cau_op_t              op3;
  logic                 dz3;
  logic        [1:0]    neg3;
  logic        [RW-1:0] mag3 [2];
  logic        [RW-1:0] den3;
  // stage 4: quotient seed, overflow check
  logic                 v4;

  logic ld1, ld2, ld3, ld4;
  assign ld4 = !v4 || out_ready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign in_ready  = ld1;
  assign out_valid = v4;

  logic [W:0] ext_are, ext_aim, ext_bre, ext_bim;
  assign ext_are = {a_re[W-1], a_re};
  assign ext_aim = {a_im[W-1], a_im};
  assign ext_bre = {b_re[W-1], b_re};
  assign ext_bim = {b_im[W-1], b_im};

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= in_valid;
    end
    if (ld1) begin
      op1  <= in_action;
      prr1 <= PW'(a_re) * PW'(b_re);
      pii1 <= PW'(a_im) * PW'(b_im);
      pri1 <= PW'(a_re) * PW'(b_im);
      pir1 <= PW'(a_im) * PW'(b_re);
      srr1 <= PW'(b_re) * PW'(b_re);
      sii1 <= PW'(b_im) * PW'(b_im);
      if (in_action == OP_SUB) begin
        add_re1 <= ext_are - ext_bre;
        add_im1 <= ext_aim - ext_bim;
      end else begin
        add_re1 <= ext_are + ext_bre;
        add_im1 <= ext_aim + ext_bim;
      end
    end
  end

  // stage 2: combine products by operation
  logic [SW-1:0] xrr, xii, xri, xir;
  assign xrr = {prr1[PW-1], prr1};
  assign xii = {pii1[PW-1], pii1};
  assign xri = {pri1[PW-1], pri1};
  assign xir = {pir1[PW-1], pir1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
    if (ld2) begin
      op2  <= op1;
      den2 <= RW'(srr1) + RW'(sii1);
      case (op1)
        OP_MUL: begin
          num2[0] <= xrr - xii;
          num2[1] <= xri + xir;
        end
        OP_DIV: begin
          num2[0] <= xrr + xii;
          num2[1] <= xir - xri;
        end
        default: begin
          num2[0] <= {{(SW-W-1){add_re1[W]}}, add_re1};
          num2[1] <= {{(SW-W-1){add_im1[W]}}, add_im1};
        end
      endcase
    end
  end

  // stage 3: absolute values
  logic [SW-1:0] absv [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      absv[l] = num2[l][SW-1] ? (~num2[l] + SW'(1)) : num2[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
    if (ld3) begin
      op3  <= op2;
      den3 <= den2;
      dz3  <= (op2 == OP_DIV) && (den2 == '0);
      for (int l = 0; l < 2; l++) begin
        neg3[l] <= num2[l][SW-1];
        mag3[l] <= absv[l][RW-1:0];
      end
    end
  end

  // stage 4: scale and seed the divider, or finish the magnitude
  logic [RW-1:0] shifted [2];
  logic [DW-1:0] dvd     [2];
  logic [DW-1:0] hi_full [2];
  logic [1:0]    big4;
  logic [QW-1:0] q4      [2];
  logic [RW-1:0] r4      [2];
  logic [QW-1:0] lo4     [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shifted[l] = (op3 == OP_MUL) ? (mag3[l] >> FRAC_BITS) : mag3[l];
      dvd[l]     = DW'(mag3[l]) << FRAC_BITS;
      hi_full[l] = dvd[l] >> QW;
      if (op3 == OP_DIV) begin
        big4[l] = !dz3 && (hi_full[l] >= DW'(den3));
        q4[l]   = '0;
        r4[l]   = hi_full[l][RW-1:0];
        lo4[l]  = dvd[l][QW-1:0];
      end else begin
        big4[l] = |shifted[l][RW-1:QW];
        q4[l]   = shifted[l][QW-1:0];
        r4[l]   = '0;
        lo4[l]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ld4) begin
      v4 <= v3;
    end
    if (ld4) begin
      out_flags.is_div <= (op3 == OP_DIV);
      out_flags.dz     <= dz3;
      out_flags.neg    <= neg3;
      out_flags.big    <= big4;
      out_den          <= den3;
      out_r            <= r4;
      out_q            <= q4;
      out_lo           <= lo4;
    end
  end

endmodule

@@ src/cau_div.sv @@
// pipelined restoring divider, one quotient bit per stage, two lanes
// depends on cau_pkg
module cau_div import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cau_flags_t              in_flags,
  input  logic [2*DATA_WIDTH-1:0] in_den,
  input  logic [2*DATA_WIDTH-1:0] in_r  [2],
  input  logic [DATA_WIDTH:0]     in_q  [2],
  input  logic [DATA_WIDTH:0]     in_lo [2],
  output logic                    out_valid,
  input  logic                    out_ready,
  output cau_flags_t              out_flags,
  output logic [DATA_WIDTH:0]     out_q [2]
);

  localparam int RW = 2 * DATA_WIDTH;
  localparam int QW = DATA_WIDTH + 1;

  logic          v_st   [QW];
  logic          rdy    [QW];
  cau_flags_t    f_st   [QW];
  logic [RW-1:0] den_st [QW];
  logic [RW-1:0] r_st   [QW][2];
  logic [QW-1:0] q_st   [QW][2];
  logic [QW-1:0] lo_st  [QW][2];

  assign in_ready  = rdy[0];
  assign out_valid = v_st[QW-1];
  assign out_flags = f_st[QW-1];
  assign out_q     = q_st[QW-1];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic          src_v;
    cau_flags_t    src_f;
    logic [RW-1:0] src_den;
    logic [RW-1:0] src_r  [2];
    logic [QW-1:0] src_q  [2];
    logic [QW-1:0] src_lo [2];
    logic [RW-1:0] nr     [2];
    logic [QW-1:0] nq     [2];
    logic [QW-1:0] nlo    [2];

    // source is the input port for the first stage, else the previous stage
    if (g == 0) begin : g_src
      assign src_v   = in_valid;
      assign src_f   = in_flags;
      assign src_den = in_den;
      assign src_r   = in_r;
      assign src_q   = in_q;
      assign src_lo  = in_lo;
    end else begin : g_src
      assign src_v   = v_st[g-1];
      assign src_f   = f_st[g-1];
      assign src_den = den_st[g-1];
      assign src_r   = r_st[g-1];
      assign src_q   = q_st[g-1];
      assign src_lo  = lo_st[g-1];
    end

    // stage ready
    if (g == QW - 1) begin : g_rdy
      assign rdy[g] = !v_st[g] || out_ready;
    end else begin : g_rdy
      assign rdy[g] = !v_st[g] || rdy[g+1];
    end

    // one restoring step per lane, other operations pass through
    always_comb begin
      logic [RW:0] t;
      logic [RW:0] d;
      for (int l = 0; l < 2; l++) begin
        t = {src_r[l], src_lo[l][QW-1]};
        d = t - {1'b0, src_den};
        if (src_f.is_div) begin
          if (t >= {1'b0, src_den}) begin
            nr[l] = d[RW-1:0];
            nq[l] = {src_q[l][QW-2:0], 1'b1};
          end else begin
            nr[l] = t[RW-1:0];
            nq[l] = {src_q[l][QW-2:0], 1'b0};
          end
          nlo[l] = {src_lo[l][QW-2:0], 1'b0};
        end else begin
          nr[l]  = src_r[l];
          nq[l]  = src_q[l];
          nlo[l] = src_lo[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_st[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_st[g] <= src_v;
      end
      if (rdy[g]) begin
        f_st[g]   <= src_f;
        den_st[g] <= src_den;
        r_st[g]   <= nr;
        q_st[g]   <= nq;
        lo_st[g]  <= nlo;
      end
    end
  end

endmodule

@@ src/cau_sat.sv @@
// output stage: sign, saturation and zero-divisor handling
// depends on cau_pkg
module cau_sat import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cau_flags_t            in_flags,
  input  logic [DATA_WIDTH:0]   in_q [2],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] res_re,
  output logic [DATA_WIDTH-1:0] res_im,
  output logic                  div_zero,
  output logic                  saturated
);

  localparam int W  = DATA_WIDTH;
  localparam int QW = W + 1;
  localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (W - 1));

  logic          ld;
  logic [1:0]    clip;
  logic [QW-1:0] m    [2];
  logic [QW-1:0] negm [2];
  logic [W-1:0]  val  [2];

  assign ld        = !out_valid || out_ready;
  assign in_ready  = ld;

  // clip each part to the signed range
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (in_flags.neg[l]) begin
        clip[l] = in_flags.big[l] || (in_q[l] > LIM_NEG);
        m[l]    = clip[l] ? LIM_NEG : in_q[l];
        negm[l] = ~m[l] + QW'(1);
        val[l]  = negm[l][W-1:0];
      end else begin
        clip[l] = in_flags.big[l] || (in_q[l] > LIM_POS);
        m[l]    = clip[l] ? LIM_POS : in_q[l];
        negm[l] = m[l];
        val[l]  = m[l][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= in_valid;
    end
    if (ld) begin
      if (in_flags.dz) begin
        res_re    <= '0;
        res_im    <= '0;
        div_zero  <= 1'b1;
        saturated <= 1'b0;
      end else begin
        res_re    <= val[0];
        res_im    <= val[1];
        div_zero  <= 1'b0;
        saturated <= |clip;
      end
    end
  end

endmodule

@@ src/complex_arithmetic_unit_top.sv @@
// top level of the pipelined complex add/subtract/multiply/divide unit
// depends on cau_pkg, cau_front, cau_div, cau_sat
//
//  channel  dir  tdata (low bit up)               tuser (low bit up)
//  s_axis   in   a_re, a_im, b_re, b_im, zeros    action[1:0]
//  m_axis   out  res_re, res_im, zeros            div_zero, saturated
//
// one transfer per cycle in and out while m_axis is not stalled; the divider
// has one stage per quotient bit
// rst is synchronous and clears only the stage valid bits
// a stall on m_axis holds every stage that is full; empty stages keep filling

module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // a_re, a_im, b_re, b_im, zero fill
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // res_re, res_im, zero fill
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // div_zero, saturated
  output logic [1:0]                    m_tuser
);

  localparam int W      = DATA_WIDTH;
  localparam int RW     = 2 * W;
  localparam int QW     = W + 1;
  localparam int OUT_TW = ((2 * W + 7) / 8) * 8;

  logic signed [W-1:0] a_re, a_im, b_re, b_im;
  assign a_re = s_tdata[W-1:0];
  assign a_im = s_tdata[2*W-1:W];
  assign b_re = s_tdata[3*W-1:2*W];
  assign b_im = s_tdata[4*W-1:3*W];

  // front end to divider
  logic          f_valid, f_ready;
  cau_flags_t    f_flags;
  logic [RW-1:0] f_den;
  logic [RW-1:0] f_r  [2];
  logic [QW-1:0] f_q  [2];
  logic [QW-1:0] f_lo [2];

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_action(cau_op_t'(s_tuser)),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_flags(f_flags),
    .out_den  (f_den),
    .out_r    (f_r),
    .out_q    (f_q),
    .out_lo   (f_lo)
  );

  // divider to output stage
  logic          d_valid, d_ready;
  cau_flags_t    d_flags;
  logic [QW-1:0] d_q [2];

  cau_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_flags (f_flags),
    .in_den   (f_den),
    .in_r     (f_r),
    .in_q     (f_q),
    .in_lo    (f_lo),
    .out_valid(d_valid),
    .out_ready(d_ready),
    .out_flags(d_flags),
    .out_q    (d_q)
  );

  logic [W-1:0] res_re, res_im;
  logic         div_zero, saturated;

  cau_sat #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_sat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_flags (d_flags),
    .in_q     (d_q),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .res_re   (res_re),
    .res_im   (res_im),
    .div_zero (div_zero),
    .saturated(saturated)
  );

  // result packing
  assign m_tdata = OUT_TW'({res_im, res_re});
  assign m_tuser = {saturated, div_zero};

endmodule

@@ verif/cau_checker.sv @@
// checker for the complex arithmetic unit: watches both stream channels,
// predicts each result from the accepted operands and compares field by field
// depends on cau_pkg
module cau_checker import cau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic        dz;
    logic        sat;
  } cau_result_t;

  cau_result_t result_q[$];

  // clip one part to 16 bits; force marks a quotient too wide to hold
  function automatic logic [15:0] clip16(input logic signed [95:0] v, input bit force_clip,
                                         inout bit clipped);
    if (v > 32767 || (force_clip && v >= 0)) begin
      clipped = 1;
      return 16'sh7fff;
    end
    if (v < -32768 || force_clip) begin
      clipped = 1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // truncating division of num << 8 by den, sign applied to the magnitude
  function automatic logic signed [95:0] quot_trunc(input logic signed [63:0] num,
                                                    input logic [63:0] den);
    logic [95:0] mag;
    logic [95:0] q;
    mag = 96'((num < 0) ? -num : num);
    q = (mag << 8) / 96'(den);
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_result_t complex_result(input cau_op_t op,
      input logic signed [15:0] ar, input logic signed [15:0] ai,
      input logic signed [15:0] br, input logic signed [15:0] bi);
    cau_result_t r;
    logic signed [95:0] vre, vim;
    logic signed [63:0] pre, pim;
    logic [63:0] den;
    bit clipped;
    clipped = 0;
    r = '0;
    vre = 0;
    vim = 0;
    case (op)
      OP_ADD: begin
        vre = 96'(ar) + 96'(br);
        vim = 96'(ai) + 96'(bi);
      end
      OP_SUB: begin
        vre = 96'(ar) - 96'(br);
        vim = 96'(ai) - 96'(bi);
      end
      OP_MUL: begin
        pre = 64'(ar) * 64'(br) - 64'(ai) * 64'(bi);
        pim = 64'(ar) * 64'(bi) + 64'(ai) * 64'(br);
        // truncate magnitude toward zero
        vre = 96'((pre < 0) ? -((-pre) >>> 8) : (pre >>> 8));
        vim = 96'((pim < 0) ? -((-pim) >>> 8) : (pim >>> 8));
      end
      OP_DIV: begin
        den = 64'(64'(br) * 64'(br)) + 64'(64'(bi) * 64'(bi));
        if (den == 0) begin
          r.dz = 1;
          return r;
        end
        pre = 64'(ar) * 64'(br) + 64'(ai) * 64'(bi);
        pim = 64'(ai) * 64'(br) - 64'(ar) * 64'(bi);
        vre = quot_trunc(pre, den);
        vim = quot_trunc(pim, den);
      end
      default: begin
        vre = 0;
        vim = 0;
      end
    endcase
    r.re = clip16(vre, 0, clipped);
    r.im = clip16(vim, 0, clipped);
    r.sat = clipped;
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    cau_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      // input transfer: queue the prediction
      if (s_tvalid && s_tready)
        result_q.push_back(complex_result(cau_op_t'(s_tuser), s_tdata[15:0],
                                          s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]));
      // output transfer: compare against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: %h %b", m_tdata, m_tuser);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (m_tdata[15:0] !== want.re) begin
            $error("res_re expected %h actual %h", want.re, m_tdata[15:0]);
            errs++;
          end
          if (m_tdata[31:16] !== want.im) begin
            $error("res_im expected %h actual %h", want.im, m_tdata[31:16]);
            errs++;
          end
          if (m_tuser[0] !== want.dz) begin
            $error("div_zero expected %b actual %b", want.dz, m_tuser[0]);
            errs++;
          end
          if (m_tuser[1] !== want.sat) begin
            $error("saturated expected %b actual %b", want.sat, m_tuser[1]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ verif/testbench.sv @@
// stimulus and verdict for the complex arithmetic unit
// depends on cau_pkg, complex_arithmetic_unit_top and cau_checker
module testbench import cau_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // a_re, a_im, b_re, b_im
  logic [1:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;        // res_re, res_im
  logic [1:0]  m_tuser;        // div_zero, saturated
  int          fail_count;
  int          pending;
  int          sent = 0;
  int          sink_idle_pct = 20;
  int          src_idle_pct = 20;
  int          op_seen[4];

  complex_arithmetic_unit_top i_dut (.*);
  cau_checker i_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // random receiver stalls
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= sink_idle_pct);

  // pick an operand value, extremes often
  function automatic logic [15:0] operand();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer, with optional random gap before it
  task automatic send_op(input cau_op_t op, input logic [15:0] ar, input logic [15:0] ai,
                         input logic [15:0] br, input logic [15:0] bi);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {bi, br, ai, ar};
    op_seen[op]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    #200000000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, every operation, zero divisor, saturation
    send_op(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_op(OP_ADD, 16'h0100, 16'hff00, 16'h0001, 16'h0000);
    send_op(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(OP_SUB, 16'h1234, 16'h4321, 16'h1234, 16'h0021);
    send_op(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(OP_MUL, 16'h0100, 16'h0000, 16'hffff, 16'h0001);
    send_op(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_op(OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    send_op(OP_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    send_op(OP_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
    send_op(OP_DIV, 16'hff00, 16'h0000, 16'h0300, 16'h0000);
    send_op(OP_DIV, 16'h0001, 16'h0001, 16'h7fff, 16'h8000);
    send_op(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    // hold off until the pipeline has drained
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    // random part, with a stretch free of stalls in the middle
    for (int n = 0; n < 2000; n++) begin
      if (n == 800) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (n == 1100) begin
        src_idle_pct = 20;
        sink_idle_pct = 20;
      end
      if ($urandom_range(15) == 0)
        send_op(OP_DIV, operand(), operand(), 16'h0000, 16'h0000);
      else if ($urandom_range(3) == 0)
        send_op(cau_op_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
      else
        send_op(cau_op_t'($urandom_range(3)), operand(), operand(), operand(), operand());
    end
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d transfers: add %0d, sub %0d, mul %0d, div %0d", sent,
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    if (fail_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule

@@ complex_arithmetic_unit_top.f @@
src/cau_pkg.sv
src/cau_front.sv
src/cau_div.sv
src/cau_sat.sv
src/complex_arithmetic_unit_top.sv
verif/cau_checker.sv
verif/testbench.sv
